// ===== rtl/med_pkg.sv =====
`timescale 1ns / 1ps

package med_pkg;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_DOT    = 2'd0,
		OP_DASH   = 2'd1,
		OP_TICK   = 2'd2,
		OP_SET_TX = 2'd3
	} op_t;

	// Widest code word the lookup accepts (elements plus sentinel)
	localparam int CODE_MAX_W   = 16;
	localparam int SYMBOL_COUNT = 36;

	localparam logic [6:0] UNKNOWN_CHAR = 7'h3F;

	// Code words of the letters a..z, then the digits 1..9 and 0
	localparam logic [5:0] SYM_CODE [SYMBOL_COUNT] = '{
		6'h06, 6'h11, 6'h15, 6'h09, 6'h02, 6'h14, 6'h0B, 6'h10, 6'h04, 6'h1E,
		6'h0D, 6'h12, 6'h07, 6'h05, 6'h0F, 6'h16, 6'h1B, 6'h0A, 6'h08, 6'h03,
		6'h0C, 6'h18, 6'h0E, 6'h19, 6'h1D, 6'h13,
		6'h3E, 6'h3C, 6'h38, 6'h30, 6'h20, 6'h21, 6'h23, 6'h27, 6'h2F, 6'h3F
	};

	// ASCII characters matching SYM_CODE
	localparam logic [6:0] SYM_CHAR [SYMBOL_COUNT] = '{
		7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68, 7'h69, 7'h6A,
		7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h6F, 7'h70, 7'h71, 7'h72, 7'h73, 7'h74,
		7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A,
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
	};

	// Match a code word against all symbols in parallel
	function automatic logic [6:0] lookup_code(input logic [CODE_MAX_W-1:0] code);
		logic [6:0] ch;
		ch = UNKNOWN_CHAR;
		for (int i = 0; i < SYMBOL_COUNT; i++) begin
			if (code == CODE_MAX_W'(SYM_CODE[i])) begin
				ch = SYM_CHAR[i];
			end
		end
		return ch;
	endfunction

endpackage

// ===== rtl/morse_element_decoder.sv =====
`timescale 1ns / 1ps
// A character leaves on m_tdata after the tick transaction that completes it has passed
// the input register, then the result register.
// Throughput: one transaction per cycle unless m_tready stalls; the single-pass
// update of the element registers and the parallel symbol match set that figure.
// Reset: arst_n clears the element state, the transmitting flag and both valid bits,
// and loads the gap threshold with 300 ms.

module morse_element_decoder import med_pkg::*; #(
	parameter int MAX_ELEMENTS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	// config: gap_threshold_ms
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	// input: op[1:0], now_ms[33:2], tx_level[34], zero fill [39:35]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	// output: letter_char[6:0], zero fill [7]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata
);

	localparam int CW    = MAX_ELEMENTS + 1;
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	// Input stage
	logic        valid_s1;
	op_t         op_s1;
	logic [31:0] now_s1;
	logic        level_s1;

	// Decoder state
	logic [31:0]      gap_q;
	logic [CW-1:0]    code_word_q;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic             pending_q;
	logic [31:0]      last_time_q;
	logic             tx_q;

	// Result register
	logic       out_valid_q;
	logic [6:0] letter_q;

	logic        advance;
	logic        is_element;
	logic        is_tick;
	logic        fire;
	logic [31:0] elapsed;
	logic [6:0]  letter_d;
	logic [CW-1:0] code_word_d;

	// Stage 1 moves on whenever the result register can take a value
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= op_t'(s_tdata[1:0]);
			now_s1   <= s_tdata[33:2];
			level_s1 <= s_tdata[34];
		end
	end

	// Decode the operation
	always_comb begin
		is_element = 1'b0;
		is_tick    = 1'b0;
		unique case (op_s1)
			OP_DOT, OP_DASH: is_element = 1'b1;
			OP_TICK:         is_tick    = 1'b1;
			OP_SET_TX:       is_element = 1'b0;
			default:         is_element = 1'b0;
		endcase
	end

	// Gap test and symbol match
	assign elapsed  = now_s1 - last_time_q;
	assign fire     = valid_s1 && advance && is_tick && pending_q && !tx_q &&
	                  (elapsed > gap_q);
	assign letter_d = overflow_q ? UNKNOWN_CHAR : lookup_code(CODE_MAX_W'(code_word_q));

	// Place the new element and move the sentinel up
	always_comb begin
		code_word_d = code_word_q;
		code_word_d[count_q] = (op_s1 == OP_DASH);
		code_word_d[CNT_W'(count_q + 1'b1)] = 1'b1;
	end

	// Update the element state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q       <= 32'd300;
			code_word_q <= '0;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			pending_q   <= 1'b0;
			last_time_q <= '0;
			tx_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				gap_q <= cfg_wdata;
			end
			if (valid_s1 && advance) begin
				if (is_element) begin
					if (count_q == CNT_W'(MAX_ELEMENTS)) begin
						overflow_q <= 1'b1;
					end else begin
						code_word_q <= code_word_d;
						count_q     <= count_q + 1'b1;
					end
					last_time_q <= now_s1;
					pending_q   <= 1'b1;
				end else if (fire) begin
					code_word_q <= '0;
					count_q     <= '0;
					overflow_q  <= 1'b0;
					pending_q   <= 1'b0;
				end else if (op_s1 == OP_SET_TX) begin
					tx_q <= level_s1;
				end
			end
		end
	end

	// Hold the result until the downstream transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			letter_q <= letter_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, letter_q};

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("element count beyond capacity");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> (count_q == CNT_W'(MAX_ELEMENTS)))
		else $error("overflow flagged with room left");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (code_word_q == '0))
		else $error("empty word holds bits");

	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (!pending_q && count_q == '0 && !overflow_q && m_tvalid))
		else $error("decode did not clear the word or present a result");
`endif

endmodule

// ===== tb/sv/morse_element_decoder_tb.sv =====
`timescale 1ns / 1ps

module morse_element_decoder_tb;
	import med_pkg::*;

	localparam int ELEM_MAX = 7;
	localparam int SYM_TOTAL = 36;
	localparam logic [6:0] QMARK = 7'h3F;
	localparam string SYMBOLS = "abcdefghijklmnopqrstuvwxyz1234567890";

	// Dot/dash patterns in the order of SYMBOLS
	string morse_pat [0:SYM_TOTAL-1] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		".----", "..---", "...--", "....-", ".....", "-....", "--...", "---..",
		"----.", "-----"
	};

	// One input transaction; op lands in the low bits of s_tdata
	typedef struct packed {
		logic        lvl;
		logic [31:0] now;
		op_t         op;
	} key_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	// Stimulus and expected characters
	key_event_t  key_events [$];
	logic [6:0]  expected_chars [$];
	int          events_queued = 0;
	int          events_taken = 0;
	int          mismatches = 0;
	logic        no_idle = 1'b0;
	logic        ev_fire = 1'b0;
	logic [6:0]  want_char;

	// Decoder state as seen by the checker
	logic [31:0] gap_ms = 32'd300;
	logic [7:0]  code_acc = '0;
	logic [2:0]  elem_cnt = '0;
	logic        too_long = 1'b0;
	logic        letter_open = 1'b0;
	logic [31:0] last_elem_ms = '0;
	logic        keying = 1'b0;

	morse_element_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	// Build the code word of a pattern: dash is 1, sentinel above the last element
	function automatic logic [15:0] pattern_code(input string pat);
		logic [15:0] code;
		code = '0;
		for (int i = 0; i < pat.len(); i++) begin
			if (pat[i] == "-") begin
				code[i] = 1'b1;
			end
		end
		code[pat.len()] = 1'b1;
		return code;
	endfunction

	function automatic logic [6:0] char_for_word(input logic [7:0] word, input logic ovf);
		logic [6:0] ch;
		byte        b;
		ch = QMARK;
		if (!ovf) begin
			for (int i = 0; i < SYM_TOTAL; i++) begin
				if (pattern_code(morse_pat[i]) == {8'b0, word}) begin
					b = SYMBOLS[i];
					ch = b[6:0];
				end
			end
		end
		return ch;
	endfunction

	// Advance the checker state by one accepted transaction
	task automatic apply_key_event(input key_event_t ev);
		logic [31:0] quiet;
		quiet = ev.now - last_elem_ms;
		case (ev.op)
			OP_DOT, OP_DASH: begin
				if (elem_cnt == ELEM_MAX) begin
					too_long = 1'b1;
				end else begin
					code_acc[elem_cnt] = (ev.op == OP_DASH);
					code_acc[elem_cnt + 1] = 1'b1;
					elem_cnt = elem_cnt + 3'd1;
				end
				last_elem_ms = ev.now;
				letter_open = 1'b1;
			end
			OP_TICK: begin
				if (letter_open && !keying && quiet > gap_ms) begin
					expected_chars.push_back(char_for_word(code_acc, too_long));
					code_acc = '0;
					elem_cnt = '0;
					too_long = 1'b0;
					letter_open = 1'b0;
				end
			end
			default: begin
				keying = ev.lvl;
			end
		endcase
	endtask

	// Drive the next transaction and the output ready on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= no_idle || ($urandom_range(99) >= 18);
			if (!s_tvalid || ev_fire) begin
				if (key_events.size() != 0 && (no_idle || $urandom_range(99) >= 18)) begin
					s_tdata <= {5'b0, key_events.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sample both sides on the rising edge: predict on input, check on output
	always @(posedge clk) begin
		if (!arst_n) begin
			ev_fire <= 1'b0;
		end else begin
			ev_fire <= s_tvalid && s_tready;
			if (cfg_we) begin
				gap_ms = cfg_wdata;
			end
			if (s_tvalid && s_tready) begin
				apply_key_event(key_event_t'(s_tdata[34:0]));
				events_taken++;
			end
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected letter, expected none, got %h", $time, m_tdata);
					mismatches++;
				end else begin
					want_char = expected_chars.pop_front();
					if (m_tdata !== {1'b0, want_char}) begin
						$display("%0t: letter mismatch, expected %h, got %h",
							$time, {1'b0, want_char}, m_tdata);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic queue_event(input op_t op, input logic [31:0] now, input logic lvl);
		key_event_t ev;
		ev.op = op;
		ev.now = now;
		ev.lvl = lvl;
		key_events.push_back(ev);
		events_queued++;
	endtask

	// Hold until every transaction is taken and every letter has come out
	task automatic wait_drained();
		@(negedge clk);
		while (events_taken != events_queued || expected_chars.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic set_gap(input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed letters with random content, some noise in between
	task automatic queue_random_phase(input int n_items, input logic [31:0] gap);
		int          base;
		int          n_elem;
		logic [31:0] t;
		base = events_queued;
		t = $urandom;
		while (events_queued - base < n_items) begin
			if ($urandom_range(99) < 15) begin
				queue_event(op_t'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
			end else begin
				n_elem = ($urandom_range(9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
				for (int i = 0; i < n_elem; i++) begin
					t += $urandom_range(gap);
					queue_event($urandom_range(1) ? OP_DASH : OP_DOT, t,
						1'($urandom_range(1)));
					// early tick that must not close the letter
					if ($urandom_range(99) < 20) begin
						queue_event(OP_TICK, t + $urandom_range(gap), 1'($urandom_range(1)));
					end
				end
				// keep the key down across a long silence
				if ($urandom_range(99) < 15) begin
					queue_event(OP_SET_TX, t, 1'b1);
					queue_event(OP_TICK, t + gap + 32'd1, 1'($urandom_range(1)));
					queue_event(OP_SET_TX, t, 1'b0);
				end
				t = t + gap + 32'd1 + $urandom_range(50);
				queue_event(OP_TICK, t, 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty tick, time zero, threshold boundary, wrapping time
		queue_event(OP_TICK, 32'd0, 1'b0);
		queue_event(OP_DOT, 32'd0, 1'b1);
		queue_event(OP_TICK, 32'd300, 1'b0);
		queue_event(OP_TICK, 32'd301, 1'b1);
		queue_event(OP_DASH, 32'hFFFF_FFF0, 1'b0);
		queue_event(OP_DASH, 32'hFFFF_FFF8, 1'b0);
		queue_event(OP_TICK, 32'h0000_0200, 1'b0);
		// Transmitting key blocks the decode until it is released
		queue_event(OP_SET_TX, 32'd0, 1'b1);
		queue_event(OP_DOT, 32'd1000, 1'b0);
		queue_event(OP_TICK, 32'd5000, 1'b0);
		queue_event(OP_SET_TX, 32'hFFFF_FFFF, 1'b0);
		queue_event(OP_TICK, 32'd5001, 1'b0);
		// Element beyond capacity
		for (int i = 0; i < 8; i++) begin
			queue_event((i % 2) ? OP_DASH : OP_DOT, 32'd6000 + i, 1'b0);
		end
		queue_event(OP_TICK, 32'd7000, 1'b0);
		// Full word of seven dashes matches nothing
		for (int i = 0; i < 7; i++) begin
			queue_event(OP_DASH, 32'd8000 + i, 1'b1);
		end
		queue_event(OP_TICK, 32'hFFFF_FFFF, 1'b1);
		wait_drained();

		set_gap(32'd0);
		queue_random_phase(250, 32'd0);
		wait_drained();

		set_gap(32'hFFFF_FFFF);
		queue_random_phase(60, 32'hFFFF_FFFF);
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			set_gap((p == 2) ? $urandom : $urandom_range(1, 2000));
			queue_random_phase(250, gap_ms);
			wait_drained();
		end

		// Run a phase with no idling on either side
		set_gap(32'd300);
		no_idle = 1'b1;
		queue_random_phase(300, 32'd300);
		wait_drained();
		no_idle = 1'b0;

		set_gap(32'd1);
		queue_random_phase(200, 32'd1);
		wait_drained();

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== morse_element_decoder.f =====
rtl/med_pkg.sv
rtl/morse_element_decoder.sv
tb/sv/morse_element_decoder_tb.sv
